// File: design/fpfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpfa_pkg
// Request and response beat types and code constants for the fixed partition
// fit allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_PLACE = 2'd1;
  localparam logic [1:0] ACT_SWAP  = 2'd2;
  localparam logic [1:0] ACT_STATS = 2'd3;

  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOFIT    = 3'd1;
  localparam logic [2:0] ST_NOVICTIM = 3'd2;
  localparam logic [2:0] ST_SMALL    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] part_start;
    logic [15:0] part_end;
    logic        part_is_free;
    logic [7:0]  proc_id;
    logic [15:0] proc_size;
    logic [7:0]  victim_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  part_index;
    logic [15:0] waste;
    logic [4:0]  free_parts;
    logic [19:0] free_space;
    logic [4:0]  frag_parts;
    logic [19:0] frag_space;
  } rsp_t;

endpackage
`default_nettype wire

// File: design/fixed_partition_fit_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator
// Fixed partition table with first, best and worst fit placement, swap and
// statistics.
//
// Requests are taken when start is high and busy is low. Every request gives
// one response beat, marked by out_valid for one cycle; the receiver cannot
// stall it. fit_mode is written on the cfg channel (always ready) while idle,
// which the user must keep; the block does not enforce it. Load: done in the
//   accept cycle, response next cycle; busy stays low for back-to-back loads.
// Place, swap, statistics: the partition table sits in a single-port RAM with
//   a registered read and is read one entry per cycle over the loaded
//   partitions. busy stays high until the response beat, so no new request
//   is taken before it; a chosen place or swap entry is written back at the
//   edge that raises out_valid.
// Reset clears the partition count, the used bits and fit_mode; sizes,
// owners and waste are not cleared, since only loaded entries are read.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator #(
  parameter int NUM_PARTS = 16,
  parameter int ADDR_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire fpfa_pkg::req_t in_data,
  output logic               out_valid,
  output fpfa_pkg::rsp_t     out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_data
);
  import fpfa_pkg::*;

  localparam int IDX_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam int CNT_W = $clog2(NUM_PARTS + 1);
  localparam logic [15:0] ADDR_MASK =
    (ADDR_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << ADDR_BITS) - 32'd1);

  typedef struct packed {
    logic [15:0] size;
    logic [7:0]  owner;
    logic [15:0] waste;
  } ent_t;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [1:0]            mode_r, mode_nxt;
  req_t                  req_r, req_nxt;
  logic [NUM_PARTS-1:0]  used_r, used_nxt;
  logic [CNT_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]      dat_idx_r, dat_idx_nxt;
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      pick_r, pick_nxt;
  logic [15:0]           pick_w_r, pick_w_nxt;
  logic [15:0]           pick_size_r, pick_size_nxt;
  logic [CNT_W-1:0]      fp_r, fp_nxt;
  logic [19:0]           fs_r, fs_nxt;
  logic [CNT_W-1:0]      gp_r, gp_nxt;
  logic [19:0]           gs_r, gs_nxt;
  logic                  out_valid_r, out_valid_nxt;
  rsp_t                  out_data_r, out_data_nxt;

  ent_t                  mem [NUM_PARTS];
  ent_t                  mem_q;
  logic                  used_q;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  ent_t                  mem_wdata;
  logic                  issue;

  logic [15:0]           start_m, end_m, load_size;
  logic                  fits;
  logic [15:0]           w;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign start_m   = in_data.part_start & ADDR_MASK;
  assign end_m     = in_data.part_end & ADDR_MASK;
  assign load_size = (end_m >= start_m) ? (end_m - start_m) : 16'd0;

  assign issue = (state_r == S_SCAN) && (rd_idx_r < cnt_r);
  assign fits  = (mem_q.size >= req_r.proc_size);
  assign w     = mem_q.size - req_r.proc_size;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    req_nxt       = req_r;
    used_nxt      = used_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = 1'b0;
    dat_idx_nxt   = dat_idx_r;
    found_nxt     = found_r;
    pick_nxt      = pick_r;
    pick_w_nxt    = pick_w_r;
    pick_size_nxt = pick_size_r;
    fp_nxt        = fp_r;
    fs_nxt        = fs_r;
    gp_nxt        = gp_r;
    gs_nxt        = gs_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r[IDX_W-1:0];
    mem_wdata     = '0;

    if (cfg_valid && cfg_ready) begin
      mode_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_data;
          if (in_data.action == ACT_LOAD) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            if (cnt_r == CNT_W'(NUM_PARTS)) begin
              out_data_nxt.status = ST_FULL;
            end else begin
              mem_we          = 1'b1;
              mem_wdata.size  = load_size;
              mem_wdata.owner = in_data.part_is_free ? 8'd0 : in_data.proc_id;
              mem_wdata.waste = 16'd0;
              used_nxt[cnt_r[IDX_W-1:0]] = !in_data.part_is_free;
              cnt_nxt = cnt_r + CNT_W'(1);
              out_data_nxt.status     = ST_OK;
              out_data_nxt.part_index = 4'(cnt_r);
            end
          end else begin
            found_nxt  = 1'b0;
            pick_nxt   = '0;
            pick_w_nxt = '0;
            fp_nxt     = '0;
            fs_nxt     = '0;
            gp_nxt     = '0;
            gs_nxt     = '0;
            rd_idx_nxt = '0;
            state_nxt  = (cnt_r == '0) ? S_FIN : S_SCAN;
          end
        end
      end

      S_SCAN: begin
        rd_vld_nxt = issue;
        if (issue) begin
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
          dat_idx_nxt = rd_idx_r[IDX_W-1:0];
        end
        if (rd_vld_r) begin
          case (req_r.action)
            ACT_PLACE: begin
              if (!used_q && fits) begin
                if (!found_r ||
                    (mode_r == MODE_BEST && w < pick_w_r) ||
                    (mode_r == MODE_WORST && w > pick_w_r)) begin
                  found_nxt     = 1'b1;
                  pick_nxt      = dat_idx_r;
                  pick_w_nxt    = w;
                  pick_size_nxt = mem_q.size;
                end
              end
            end
            ACT_SWAP: begin
              if (!found_r && used_q && mem_q.owner == req_r.victim_id) begin
                found_nxt     = 1'b1;
                pick_nxt      = dat_idx_r;
                pick_size_nxt = mem_q.size;
              end
            end
            default: begin
              if (!used_q) begin
                fp_nxt = fp_r + CNT_W'(1);
                fs_nxt = fs_r + 20'(mem_q.size);
              end else if (mem_q.waste != 16'd0) begin
                gp_nxt = gp_r + CNT_W'(1);
                gs_nxt = gs_r + 20'(mem_q.waste);
              end
            end
          endcase
          if (CNT_W'(dat_idx_r) == cnt_r - CNT_W'(1)) begin
            state_nxt = S_FIN;
          end
        end
      end

      S_FIN: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        mem_waddr     = pick_r;
        state_nxt     = S_IDLE;
        case (req_r.action)
          ACT_PLACE: begin
            if (found_r) begin
              mem_we          = 1'b1;
              mem_wdata.size  = pick_size_r;
              mem_wdata.owner = req_r.proc_id;
              mem_wdata.waste = pick_w_r;
              used_nxt[pick_r] = 1'b1;
              out_data_nxt.status     = ST_OK;
              out_data_nxt.part_index = 4'(pick_r);
              out_data_nxt.waste      = pick_w_r;
            end else begin
              out_data_nxt.status = ST_NOFIT;
            end
          end
          ACT_SWAP: begin
            if (!found_r) begin
              out_data_nxt.status = ST_NOVICTIM;
            end else if (pick_size_r < req_r.proc_size) begin
              out_data_nxt.status = ST_SMALL;
            end else begin
              mem_we          = 1'b1;
              mem_wdata.size  = pick_size_r;
              mem_wdata.owner = req_r.proc_id;
              mem_wdata.waste = pick_size_r - req_r.proc_size;
              out_data_nxt.status     = ST_OK;
              out_data_nxt.part_index = 4'(pick_r);
              out_data_nxt.waste      = pick_size_r - req_r.proc_size;
            end
          end
          default: begin
            out_data_nxt.status     = ST_OK;
            out_data_nxt.free_parts = 5'(fp_r);
            out_data_nxt.free_space = fs_r;
            out_data_nxt.frag_parts = 5'(gp_r);
            out_data_nxt.frag_space = gs_r;
          end
        endcase
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      mode_r      <= MODE_FIRST;
      used_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      mode_r      <= mode_nxt;
      used_r      <= used_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r       <= req_nxt;
    rd_idx_r    <= rd_idx_nxt;
    dat_idx_r   <= dat_idx_nxt;
    found_r     <= found_nxt;
    pick_r      <= pick_nxt;
    pick_w_r    <= pick_w_nxt;
    pick_size_r <= pick_size_nxt;
    fp_r        <= fp_nxt;
    fs_r        <= fs_nxt;
    gp_r        <= gp_nxt;
    gs_r        <= gs_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      mem_q  <= mem[rd_idx_r[IDX_W-1:0]];
      used_q <= used_r[rd_idx_r[IDX_W-1:0]];
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NUM_PARTS))
    else $error("partition count above table depth");

  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.action == ACT_LOAD && cnt_r != CNT_W'(NUM_PARTS))
    |=> (cnt_r == $past(cnt_r) + CNT_W'(1)) && out_valid)
    else $error("load did not advance the partition count");

  a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> out_valid && !busy)
    else $error("final step gave no response beat");

  a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r == S_SCAN) && (state_r == S_SCAN))
    else $error("read data valid outside a scan");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !mem_we && (cnt_r == $past(cnt_r)))
    else $error("table modified during a scan");

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed partition fit allocator. A queue-fed
// driver issues load, place, swap and statistics requests in random bursts;
// a monitor predicts each accepted beat against a private copy of the
// partition table and checks every response field in order. fit_mode is
// reprogrammed between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb_top;
  import fpfa_pkg::*;

  localparam int NPARTS    = 16;
  localparam int SETTLE    = 24;
  localparam int PHASE_LEN = 265;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic start     = 1'b0;
  req_t in_data   = '0;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_data = MODE_FIRST;
  logic busy;
  logic out_valid;
  rsp_t out_data;
  logic cfg_ready;

  fixed_partition_fit_allocator #(
    .NUM_PARTS(NPARTS),
    .ADDR_BITS(16)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // shadow partition table
  logic [15:0] tab_size [NPARTS];
  logic [7:0]  tab_owner[NPARTS];
  logic        tab_used [NPARTS];
  logic [15:0] tab_waste[NPARTS];
  int unsigned tab_count = 0;
  logic [1:0]  fit_sel = MODE_FIRST;

  req_t pending[$];
  rsp_t alloc_expect[$];
  int   items_queued = 0;
  int   items_taken  = 0;
  int   results_seen = 0;
  int   errors       = 0;
  int   gen_loads    = 0;
  int   status_cnt[5];
  int   mode_cnt[4];
  bit   took_beat = 1'b0;
  int   gap_left   = 0;
  int   burst_left = 1;

  initial begin
    foreach (tab_used[i]) tab_used[i] = 1'b0;
    foreach (status_cnt[i]) status_cnt[i] = 0;
    foreach (mode_cnt[i]) mode_cnt[i] = 0;
  end

  task automatic alloc_predict(input req_t r, output rsp_t e);
    int n;
    int pick;
    logic [15:0] pick_w;
    logic [15:0] w;
    bit found;
    logic [4:0] fp, gp;
    logic [19:0] fs, gs;
    e = '0;
    n = tab_count;
    found = 1'b0;
    pick = 0;
    pick_w = '0;
    case (r.action)
      ACT_LOAD: begin
        if (tab_count >= NPARTS) begin
          e.status = ST_FULL;
        end else begin
          tab_size[n]  = (r.part_end >= r.part_start) ? r.part_end - r.part_start : 16'd0;
          tab_used[n]  = !r.part_is_free;
          tab_owner[n] = r.part_is_free ? 8'h00 : r.proc_id;
          tab_waste[n] = '0;
          tab_count++;
          e.status = ST_OK;
          e.part_index = n[3:0];
        end
      end
      ACT_PLACE: begin
        for (int i = 0; i < n; i++) begin
          if (!tab_used[i] && tab_size[i] >= r.proc_size) begin
            w = tab_size[i] - r.proc_size;
            if (!found) begin
              found = 1'b1;
              pick = i;
              pick_w = w;
            end else if ((fit_sel == MODE_BEST && w < pick_w) ||
                         (fit_sel == MODE_WORST && w > pick_w)) begin
              pick = i;
              pick_w = w;
            end
          end
        end
        if (!found) begin
          e.status = ST_NOFIT;
        end else begin
          tab_used[pick]  = 1'b1;
          tab_owner[pick] = r.proc_id;
          tab_waste[pick] = pick_w;
          e.status = ST_OK;
          e.part_index = pick[3:0];
          e.waste = pick_w;
        end
      end
      ACT_SWAP: begin
        for (int i = 0; i < n; i++) begin
          if (!found && tab_used[i] && tab_owner[i] == r.victim_id) begin
            found = 1'b1;
            pick = i;
          end
        end
        if (!found) begin
          e.status = ST_NOVICTIM;
        end else if (tab_size[pick] < r.proc_size) begin
          e.status = ST_SMALL;
        end else begin
          tab_owner[pick] = r.proc_id;
          tab_waste[pick] = tab_size[pick] - r.proc_size;
          e.status = ST_OK;
          e.part_index = pick[3:0];
          e.waste = tab_waste[pick];
        end
      end
      default: begin
        fp = '0;
        gp = '0;
        fs = '0;
        gs = '0;
        for (int i = 0; i < n; i++) begin
          if (!tab_used[i]) begin
            fp++;
            fs += tab_size[i];
          end else if (tab_waste[i] != 0) begin
            gp++;
            gs += tab_waste[i];
          end
        end
        e.status = ST_OK;
        e.free_parts = fp;
        e.free_space = fs;
        e.frag_parts = gp;
        e.frag_space = gs;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [19:0] want,
                             input logic [19:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // driver: one beat per accepted request, bursts separated by gaps
  always @(negedge clk) begin
    if (!(start && !took_beat)) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (rst_n && pending.size() > 0) begin
        in_data <= pending.pop_front();
        start   <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 120)
                                                   : $urandom_range(1, 8);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check responses, then predict the beat taken at this edge
  always @(posedge clk) begin : mon
    rsp_t want;
    took_beat = rst_n && start && !busy;
    if (rst_n && out_valid) begin
      if (alloc_expect.size() == 0) begin
        errors++;
        $display("%0t: response with nothing expected, actual %p", $time, out_data);
      end else begin
        want = alloc_expect.pop_front();
        check_field("status",     20'(want.status),     20'(out_data.status));
        check_field("part_index", 20'(want.part_index), 20'(out_data.part_index));
        check_field("waste",      20'(want.waste),      20'(out_data.waste));
        check_field("free_parts", 20'(want.free_parts), 20'(out_data.free_parts));
        check_field("free_space", want.free_space,      out_data.free_space);
        check_field("frag_parts", 20'(want.frag_parts), 20'(out_data.frag_parts));
        check_field("frag_space", want.frag_space,      out_data.frag_space);
        results_seen++;
      end
    end
    if (took_beat) begin
      alloc_predict(in_data, want);
      alloc_expect.push_back(want);
      if (want.status < 5) status_cnt[want.status]++;
      if (in_data.action == ACT_PLACE) mode_cnt[fit_sel]++;
      items_taken++;
    end
  end

  function automatic logic [7:0] pick_pid();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, 7));
  endfunction

  function automatic logic [15:0] pick_need();
    return ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                       : 16'($urandom_range(0, 120));
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.action       = 2'($urandom_range(0, 3));
    r.part_start   = 16'($urandom_range(0, 65535));
    r.part_end     = 16'($urandom_range(0, 65535));
    r.part_is_free = 1'($urandom_range(0, 1));
    r.proc_id      = 8'($urandom_range(0, 255));
    r.proc_size    = 16'($urandom_range(0, 65535));
    r.victim_id    = 8'($urandom_range(0, 255));
    return r;
  endfunction

  task automatic send(input req_t r);
    if (r.action == ACT_LOAD) gen_loads++;
    pending.push_back(r);
    items_queued++;
  endtask

  task automatic send_op(input logic [1:0] act, input logic [15:0] s, input logic [15:0] e,
                         input logic fr, input logic [7:0] pid, input logic [15:0] need,
                         input logic [7:0] vic);
    req_t r;
    r = rand_req();
    r.action = act;
    if (act == ACT_LOAD) begin
      r.part_start = s;
      r.part_end = e;
      r.part_is_free = fr;
    end
    r.proc_id = pid;
    r.proc_size = need;
    r.victim_id = vic;
    send(r);
  endtask

  task automatic drain();
    while (items_taken != items_queued || alloc_expect.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    fit_sel = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stim
    logic [1:0] phase_mode[6];
    logic [15:0] base, span;
    req_t r;
    int k;
    phase_mode = '{MODE_BEST, MODE_WORST, 2'd3, MODE_FIRST, MODE_BEST, MODE_WORST};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // empty table, then corner loads and first fit under the reset mode
    send_op(ACT_STATS, 0, 0, 0, 8'h00, 16'h0000, 8'h00);
    send_op(ACT_PLACE, 0, 0, 0, 8'h01, 16'h0000, 8'h00);
    send_op(ACT_SWAP,  0, 0, 0, 8'h02, 16'h0000, 8'h05);
    send_op(ACT_LOAD,  16'h0000, 16'hFFFF, 1'b1, 8'h00, 16'h0000, 8'h00);
    send_op(ACT_LOAD,  16'hFFFF, 16'h0000, 1'b1, 8'hFF, 16'hFFFF, 8'hFF);
    send_op(ACT_LOAD,  16'h1000, 16'h1100, 1'b0, 8'hFF, 16'h0000, 8'h00);
    send_op(ACT_LOAD,  16'h2000, 16'h2040, 1'b1, 8'h00, 16'h0000, 8'h00);
    send_op(ACT_PLACE, 0, 0, 0, 8'h11, 16'd64,   8'h00);
    send_op(ACT_PLACE, 0, 0, 0, 8'h12, 16'h0000, 8'h00);
    send_op(ACT_PLACE, 0, 0, 0, 8'h13, 16'hFFFF, 8'h00);
    send_op(ACT_SWAP,  0, 0, 0, 8'h00, 16'hFFFF, 8'hFF);
    send_op(ACT_SWAP,  0, 0, 0, 8'h00, 16'd200,  8'hFF);
    send_op(ACT_SWAP,  0, 0, 0, 8'h00, 16'd200,  8'hFF);
    send_op(ACT_STATS, 0, 0, 0, 8'h00, 16'h0000, 8'h00);
    send_op(ACT_SWAP,  0, 0, 0, 8'hAA, 16'h0000, 8'h11);
    send_op(ACT_STATS, 0, 0, 0, 8'h00, 16'h0000, 8'h00);
    drain();

    // worst fit must take an exact fit
    set_mode(MODE_WORST);
    @(posedge clk);
    send_op(ACT_LOAD,  16'h0000, 16'h8000, 1'b1, 8'h00, 16'h0000, 8'h00);
    send_op(ACT_PLACE, 0, 0, 0, 8'h21, 16'h8000, 8'h00);
    send_op(ACT_STATS, 0, 0, 0, 8'h00, 16'h0000, 8'h00);
    drain();

    foreach (phase_mode[p]) begin
      set_mode(phase_mode[p]);
      @(posedge clk);
      repeat (2) begin
        if (gen_loads <= NPARTS) begin
          span = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                             : 16'($urandom_range(0, 6) * 16);
          base = 16'($urandom_range(0, 65535));
          send_op(ACT_LOAD, base, base + span, 1'($urandom_range(0, 3) != 0),
                  pick_pid(), 16'h0000, 8'h00);
        end
      end
      for (int j = 0; j < PHASE_LEN; j++) begin
        k = $urandom_range(0, 99);
        r = rand_req();
        if (k < 10) begin
          if (r.action == ACT_LOAD && gen_loads < NPARTS) r.action = ACT_STATS;
        end else if (k < 45) begin
          r.action = ACT_SWAP;
          r.proc_id = pick_pid();
          r.proc_size = pick_need();
          r.victim_id = pick_pid();
        end else if (k < 65) begin
          r.action = ACT_PLACE;
          r.proc_id = pick_pid();
          r.proc_size = pick_need();
        end else if (k < 85 || gen_loads < NPARTS) begin
          r.action = ACT_STATS;
        end else begin
          r.action = ACT_LOAD;
        end
        send(r);
      end
      drain();
    end

    if (alloc_expect.size() != 0) begin
      errors++;
      $display("%0t: %0d responses never arrived", $time, alloc_expect.size());
    end
    $display("Covered %0d requests, %0d responses", items_taken, results_seen);
    $display("Status ok/nofit/novictim/small/full: %0d/%0d/%0d/%0d/%0d",
             status_cnt[0], status_cnt[1], status_cnt[2], status_cnt[3], status_cnt[4]);
    $display("Placements per fit mode first/best/worst/unused: %0d/%0d/%0d/%0d",
             mode_cnt[0], mode_cnt[1], mode_cnt[2], mode_cnt[3]);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("%0t: run timed out", $time);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
